/* sv/tqc_pkg.sv */
`timescale 1ns / 1ps
package tqc_pkg;

  // divider: quotient bits (one per stage) and divisor width
  localparam int DIV_NW = 53;
  localparam int DIV_DW = 33;

  localparam int P_W = 36;   // edge positions
  localparam int T_W = 56;   // texture coordinates before saturation
  localparam int K_W = 38;   // tile counts

  localparam int CFG_IW = 8;
  localparam logic [CFG_IW-1:0] CFG_OFFSET_X = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_OFFSET_Y = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] CFG_REPEAT_X = CFG_IW'(2);
  localparam logic [CFG_IW-1:0] CFG_REPEAT_Y = CFG_IW'(3);

  // pipeline stage map
  localparam int ST_A    = 0;
  localparam int ST_B    = DIV_NW + 1;
  localparam int ST_E    = DIV_NW + 2;
  localparam int NSTG    = 2 * DIV_NW + 3;

  typedef logic signed [31:0]    fix_t;
  typedef logic signed [P_W-1:0] pos_t;
  typedef logic signed [T_W-1:0] tex_t;
  typedef logic signed [K_W-1:0] cnt_t;

  localparam tex_t FIX_ONE = T_W'(65536);

  typedef struct packed {
    logic [DIV_DW-1:0] rem;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_st_t;

  // after placement
  typedef struct packed {
    pos_t        p1;
    pos_t        p2;
    tex_t        t1;
    tex_t        t2;
    logic [31:0] d;
    logic        dt_neg;
    logic        rep;
    logic        n1_neg;
    logic        n2_neg;
    fix_t        b1;
    fix_t        b2;
    fix_t        c1;
    fix_t        c2;
  } axa_t;

  typedef struct packed {
    axa_t ax;
    axa_t ay;
    logic canvas;
  } sba_t;

  // after tiling
  typedef struct packed {
    pos_t        p1;
    pos_t        p2;
    tex_t        t1;
    tex_t        t2;
    logic [31:0] d;
    logic        dt_neg;
    logic        rep;
    fix_t        b1;
    fix_t        b2;
    fix_t        c1;
    fix_t        c2;
  } axb_t;

  typedef struct packed {
    axb_t ax;
    axb_t ay;
    logic canvas;
  } sbb_t;

  // after clip setup
  typedef struct packed {
    pos_t        p1;
    pos_t        p2;
    tex_t        t1;
    tex_t        t2;
    logic [31:0] d;
    fix_t        c1;
    fix_t        c2;
    logic        lo;
    logic        hi;
    logic        nlo_neg;
    logic        nhi_neg;
  } axe_t;

  typedef struct packed {
    axe_t ax;
    axe_t ay;
    logic outside;
    logic canvas;
  } sbe_t;

  typedef struct packed {
    fix_t qxl;
    fix_t qxh;
    fix_t qyl;
    fix_t qyh;
    fix_t tul;
    fix_t tuh;
    fix_t tvl;
    fix_t tvh;
    logic outside;
  } res_t;

endpackage

/* sv/tqc_if.sv */
`timescale 1ns / 1ps
interface tqc_in_if;
  logic              valid;
  logic              ready;
  logic              canvas_mode;
  logic signed [31:0] canvas_left;
  logic signed [31:0] canvas_right;
  logic signed [31:0] canvas_upper;
  logic signed [31:0] canvas_lower;
  logic signed [31:0] scene_x_low;
  logic signed [31:0] scene_x_high;
  logic signed [31:0] scene_y_low;
  logic signed [31:0] scene_y_high;
  logic signed [31:0] image_w;
  logic signed [31:0] image_h;

  modport source (
    output valid, canvas_mode, canvas_left, canvas_right, canvas_upper, canvas_lower,
           scene_x_low, scene_x_high, scene_y_low, scene_y_high, image_w, image_h,
    input  ready
  );
  modport sink (
    input  valid, canvas_mode, canvas_left, canvas_right, canvas_upper, canvas_lower,
           scene_x_low, scene_x_high, scene_y_low, scene_y_high, image_w, image_h,
    output ready
  );
endinterface

interface tqc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quad_x_low;
  logic signed [31:0] quad_x_high;
  logic signed [31:0] quad_y_low;
  logic signed [31:0] quad_y_high;
  logic signed [31:0] tex_u_low;
  logic signed [31:0] tex_u_high;
  logic signed [31:0] tex_v_low;
  logic signed [31:0] tex_v_high;
  logic               outside_canvas;

  modport source (
    output valid, quad_x_low, quad_x_high, quad_y_low, quad_y_high,
           tex_u_low, tex_u_high, tex_v_low, tex_v_high, outside_canvas,
    input  ready
  );
  modport sink (
    input  valid, quad_x_low, quad_x_high, quad_y_low, quad_y_high,
           tex_u_low, tex_u_high, tex_v_low, tex_v_high, outside_canvas,
    output ready
  );
endinterface

interface tqc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tqc_pkg::CFG_IW-1:0]  index;
  logic [31:0]                 data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/tiled_quad_clip_uv.sv */
`timescale 1ns / 1ps
// Tiled image quad setup with canvas clipping. Each transfer on in_if yields
// exactly one transfer on out_if, in order. One item enters per cycle unless
// the skid entry is occupied; input to output runs through two
// 53-stage restoring dividers (tile count, then clip texture interpolation)
// in series, one quotient bit per stage. A one-entry skid after
// the output register keeps input transfers going while a result waits.
// Config writes (cfg_if, always ready) go to offset_x, offset_y, repeat_x_on,
// repeat_y_on at indexes 0..3; other indexes are dropped. Write config only
// while the pipeline is empty. All coordinates are signed Q16.16 and every
// output is saturated to 32 bits.
module tiled_quad_clip_uv (
  input  logic       clk,
  input  logic       rst_n,
  tqc_in_if.sink     in_if,
  tqc_out_if.source  out_if,
  tqc_cfg_if.sink    cfg_if
);
  import tqc_pkg::*;

  // ---------------- configuration ----------------
  fix_t offset_x_r;
  fix_t offset_y_r;
  logic rep_x_r;
  logic rep_y_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= '0;
      offset_y_r <= '0;
      rep_x_r    <= 1'b0;
      rep_y_r    <= 1'b0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_OFFSET_X: offset_x_r <= cfg_if.data;
        CFG_OFFSET_Y: offset_y_r <= cfg_if.data;
        CFG_REPEAT_X: rep_x_r    <= cfg_if.data[0];
        CFG_REPEAT_Y: rep_y_r    <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // Global advance; stalls only when the skid entry is occupied.
  logic            en;
  logic [NSTG-1:0] v_r;
  logic            ov_r;
  logic            sv_r;
  res_t            od_r;
  res_t            sd_r;
  res_t            res_nxt;

  assign en          = !sv_r;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_if.valid};
    end
  end

  // ---------------- helpers ----------------
  function automatic fix_t sat32(tex_t v);
    if (v > tex_t'(32'sh7FFFFFFF)) begin
      return 32'sh7FFFFFFF;
    end else if (v < tex_t'(-(64'sd2147483648))) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic axa_t place_axis(fix_t corner, fix_t off, fix_t size, logic t_low_one,
                                      logic rep, fix_t b1, fix_t b2, fix_t c1, fix_t c2);
    axa_t a;
    pos_t q1;
    pos_t q2;
    tex_t tl;
    tex_t th;
    logic neg;
    q1       = pos_t'(corner) + pos_t'(off);
    q2       = q1 + pos_t'(size);
    neg      = size[31];
    tl       = t_low_one ? FIX_ONE : '0;
    th       = t_low_one ? '0 : FIX_ONE;
    a.p1     = neg ? q2 : q1;
    a.p2     = neg ? q1 : q2;
    a.t1     = neg ? th : tl;
    a.t2     = neg ? tl : th;
    a.d      = 32'(a.p2 - a.p1);
    a.dt_neg = t_low_one ^ neg;
    a.rep    = rep && (a.d != '0);
    a.n1_neg = 1'b0;
    a.n2_neg = 1'b0;
    a.b1     = b1;
    a.b2     = b2;
    a.c1     = c1;
    a.c2     = c2;
    return a;
  endfunction

  function automatic logic [DIV_NW-1:0] mag_pos(pos_t v);
    pos_t m;
    m = v[P_W-1] ? -v : v;
    return DIV_NW'($unsigned(m));
  endfunction

  function automatic logic [DIV_NW-1:0] mag_tex(tex_t v);
    tex_t m;
    m = v[T_W-1] ? -v : v;
    return DIV_NW'($unsigned(m));
  endfunction

  // floor quotient from magnitude quotient and remainder
  function automatic tex_t floor_q(logic [DIV_NW-1:0] q, logic [DIV_DW-1:0] r, logic neg);
    tex_t qe;
    qe = tex_t'(q);
    return neg ? -(qe + tex_t'(r != '0)) : qe;
  endfunction

  function automatic axb_t tile_axis(axa_t a, logic [DIV_NW-1:0] q1, logic [DIV_DW-1:0] r1,
                                     logic [DIV_NW-1:0] q2, logic [DIV_DW-1:0] r2);
    axb_t              b;
    cnt_t              k1;
    cnt_t              k2;
    logic [DIV_DW-1:0] m1;
    logic [DIV_DW-1:0] m2;
    tex_t              s1;
    tex_t              s2;
    k1 = a.n1_neg ? -(q1[K_W-1:0] + K_W'(r1 != '0)) : q1[K_W-1:0];
    k2 = (a.n2_neg ? -(q2[K_W-1:0] + K_W'(r2 != '0)) : q2[K_W-1:0]) + cnt_t'(1);
    m1 = (a.n1_neg && r1 != '0) ? {1'b0, a.d} - r1 : (a.n1_neg ? '0 : r1);
    m2 = (a.n2_neg && r2 != '0) ? {1'b0, a.d} - r2 : (a.n2_neg ? '0 : r2);
    s1 = tex_t'(k1) <<< 16;
    s2 = tex_t'(k2) <<< 16;
    b.p1     = a.rep ? pos_t'(a.b1) - pos_t'(m1) : a.p1;
    b.p2     = a.rep ? pos_t'(a.b2) - pos_t'(m2) + pos_t'(a.d) : a.p2;
    b.t1     = a.rep ? (a.dt_neg ? a.t1 - s1 : a.t1 + s1) : a.t1;
    b.t2     = a.rep ? (a.dt_neg ? a.t2 - s2 : a.t2 + s2) : a.t2;
    b.d      = a.d;
    b.dt_neg = a.dt_neg;
    b.rep    = a.rep;
    b.b1     = a.b1;
    b.b2     = a.b2;
    b.c1     = a.c1;
    b.c2     = a.c2;
    return b;
  endfunction

  // signed numerator 2*dt*(c - p1) + d with dt = +-1.0
  function automatic tex_t clip_num(axb_t b, fix_t c);
    tex_t x;
    tex_t sh;
    x  = tex_t'(pos_t'(c) - b.p1);
    sh = x <<< 17;
    return (b.dt_neg ? -sh : sh) + tex_t'(b.d);
  endfunction

  // ---------------- stage A: placement ----------------
  sba_t              sba_nxt;
  sba_t              sba_r;
  logic [DIV_NW-1:0] tnum_nxt [4];
  logic [DIV_NW-1:0] tnum_r   [4];
  pos_t              n_x1;
  pos_t              n_x2;
  pos_t              n_y1;
  pos_t              n_y2;

  always_comb begin
    sba_nxt.canvas = in_if.canvas_mode;
    sba_nxt.ax = place_axis(in_if.canvas_left, offset_x_r, in_if.image_w, 1'b0, rep_x_r,
                            in_if.canvas_mode ? in_if.canvas_left : in_if.scene_x_low,
                            in_if.canvas_mode ? in_if.canvas_right : in_if.scene_x_high,
                            in_if.canvas_left, in_if.canvas_right);
    sba_nxt.ay = place_axis(in_if.canvas_upper, offset_y_r, in_if.image_h, 1'b1, rep_y_r,
                            in_if.canvas_mode ? in_if.canvas_upper : in_if.scene_y_low,
                            in_if.canvas_mode ? in_if.canvas_lower : in_if.scene_y_high,
                            in_if.canvas_upper, in_if.canvas_lower);
    n_x1 = pos_t'(sba_nxt.ax.b1) - sba_nxt.ax.p1;
    n_x2 = pos_t'(sba_nxt.ax.b2) - sba_nxt.ax.p2;
    n_y1 = pos_t'(sba_nxt.ay.b1) - sba_nxt.ay.p1;
    n_y2 = pos_t'(sba_nxt.ay.b2) - sba_nxt.ay.p2;
    sba_nxt.ax.n1_neg = n_x1[P_W-1];
    sba_nxt.ax.n2_neg = n_x2[P_W-1];
    sba_nxt.ay.n1_neg = n_y1[P_W-1];
    sba_nxt.ay.n2_neg = n_y2[P_W-1];
    tnum_nxt[0] = mag_pos(n_x1);
    tnum_nxt[1] = mag_pos(n_x2);
    tnum_nxt[2] = mag_pos(n_y1);
    tnum_nxt[3] = mag_pos(n_y2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sba_r <= sba_nxt;
      for (int i = 0; i < 4; i++) begin
        tnum_r[i] <= tnum_nxt[i];
      end
    end
  end

  // ---------------- tile-count dividers ----------------
  logic [DIV_NW-1:0] tq [4];
  logic [DIV_DW-1:0] tr [4];
  sba_t              sbt_r [DIV_NW];

  tqc_div u_tdiv_x1 (.clk(clk), .en(en), .num(tnum_r[0]), .den({1'b0, sba_r.ax.d}),
                     .quo(tq[0]), .rem(tr[0]));
  tqc_div u_tdiv_x2 (.clk(clk), .en(en), .num(tnum_r[1]), .den({1'b0, sba_r.ax.d}),
                     .quo(tq[1]), .rem(tr[1]));
  tqc_div u_tdiv_y1 (.clk(clk), .en(en), .num(tnum_r[2]), .den({1'b0, sba_r.ay.d}),
                     .quo(tq[2]), .rem(tr[2]));
  tqc_div u_tdiv_y2 (.clk(clk), .en(en), .num(tnum_r[3]), .den({1'b0, sba_r.ay.d}),
                     .quo(tq[3]), .rem(tr[3]));

  always_ff @(posedge clk) begin
    if (en) begin
      sbt_r[0] <= sba_r;
      for (int k = 1; k < DIV_NW; k++) begin
        sbt_r[k] <= sbt_r[k-1];
      end
    end
  end

  // ---------------- stage B: apply tiles ----------------
  sbb_t sbb_nxt;
  sbb_t sbb_r;

  always_comb begin
    sbb_nxt.canvas = sbt_r[DIV_NW-1].canvas;
    sbb_nxt.ax = tile_axis(sbt_r[DIV_NW-1].ax, tq[0], tr[0], tq[1], tr[1]);
    sbb_nxt.ay = tile_axis(sbt_r[DIV_NW-1].ay, tq[2], tr[2], tq[3], tr[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbb_r <= sbb_nxt;
    end
  end

  // ---------------- stage E: canvas test, clip setup ----------------
  sbe_t              sbe_nxt;
  sbe_t              sbe_r;
  logic [DIV_NW-1:0] cnum_nxt [4];
  logic [DIV_NW-1:0] cnum_r   [4];
  tex_t              cn_xl;
  tex_t              cn_xh;
  tex_t              cn_yl;
  tex_t              cn_yh;
  logic              clip_go;

  always_comb begin
    sbe_nxt.canvas  = sbb_r.canvas;
    sbe_nxt.outside = sbb_r.canvas &&
                      (sbb_r.ax.p1 >= pos_t'(sbb_r.ax.c2) || sbb_r.ax.p2 <= pos_t'(sbb_r.ax.c1) ||
                       sbb_r.ay.p1 >= pos_t'(sbb_r.ay.c2) || sbb_r.ay.p2 <= pos_t'(sbb_r.ay.c1));
    clip_go = sbb_r.canvas && !sbe_nxt.outside;
    cn_xl = clip_num(sbb_r.ax, sbb_r.ax.c1);
    cn_xh = clip_num(sbb_r.ax, sbb_r.ax.c2);
    cn_yl = clip_num(sbb_r.ay, sbb_r.ay.c1);
    cn_yh = clip_num(sbb_r.ay, sbb_r.ay.c2);

    sbe_nxt.ax.p1      = sbb_r.ax.p1;
    sbe_nxt.ax.p2      = sbb_r.ax.p2;
    sbe_nxt.ax.t1      = sbb_r.ax.t1;
    sbe_nxt.ax.t2      = sbb_r.ax.t2;
    sbe_nxt.ax.d       = sbb_r.ax.d;
    sbe_nxt.ax.c1      = sbb_r.ax.c1;
    sbe_nxt.ax.c2      = sbb_r.ax.c2;
    sbe_nxt.ax.lo      = clip_go && (sbb_r.ax.p1 < pos_t'(sbb_r.ax.c1));
    sbe_nxt.ax.hi      = clip_go && (sbb_r.ax.p2 > pos_t'(sbb_r.ax.c2));
    sbe_nxt.ax.nlo_neg = cn_xl[T_W-1];
    sbe_nxt.ax.nhi_neg = cn_xh[T_W-1];

    sbe_nxt.ay.p1      = sbb_r.ay.p1;
    sbe_nxt.ay.p2      = sbb_r.ay.p2;
    sbe_nxt.ay.t1      = sbb_r.ay.t1;
    sbe_nxt.ay.t2      = sbb_r.ay.t2;
    sbe_nxt.ay.d       = sbb_r.ay.d;
    sbe_nxt.ay.c1      = sbb_r.ay.c1;
    sbe_nxt.ay.c2      = sbb_r.ay.c2;
    sbe_nxt.ay.lo      = clip_go && (sbb_r.ay.p1 < pos_t'(sbb_r.ay.c1));
    sbe_nxt.ay.hi      = clip_go && (sbb_r.ay.p2 > pos_t'(sbb_r.ay.c2));
    sbe_nxt.ay.nlo_neg = cn_yl[T_W-1];
    sbe_nxt.ay.nhi_neg = cn_yh[T_W-1];

    cnum_nxt[0] = mag_tex(cn_xl);
    cnum_nxt[1] = mag_tex(cn_xh);
    cnum_nxt[2] = mag_tex(cn_yl);
    cnum_nxt[3] = mag_tex(cn_yh);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbe_r <= sbe_nxt;
      for (int i = 0; i < 4; i++) begin
        cnum_r[i] <= cnum_nxt[i];
      end
    end
  end

  // ---------------- clip interpolation dividers (by 2d) ----------------
  logic [DIV_NW-1:0] cq [4];
  logic [DIV_DW-1:0] cr [4];
  sbe_t              sbc_r [DIV_NW];

  tqc_div u_cdiv_xl (.clk(clk), .en(en), .num(cnum_r[0]), .den({sbe_r.ax.d, 1'b0}),
                     .quo(cq[0]), .rem(cr[0]));
  tqc_div u_cdiv_xh (.clk(clk), .en(en), .num(cnum_r[1]), .den({sbe_r.ax.d, 1'b0}),
                     .quo(cq[1]), .rem(cr[1]));
  tqc_div u_cdiv_yl (.clk(clk), .en(en), .num(cnum_r[2]), .den({sbe_r.ay.d, 1'b0}),
                     .quo(cq[2]), .rem(cr[2]));
  tqc_div u_cdiv_yh (.clk(clk), .en(en), .num(cnum_r[3]), .den({sbe_r.ay.d, 1'b0}),
                     .quo(cq[3]), .rem(cr[3]));

  always_ff @(posedge clk) begin
    if (en) begin
      sbc_r[0] <= sbe_r;
      for (int k = 1; k < DIV_NW; k++) begin
        sbc_r[k] <= sbc_r[k-1];
      end
    end
  end

  // ---------------- final: clipped edges, texture coords, saturation ----------------
  sbe_t fin;

  assign fin = sbc_r[DIV_NW-1];

  always_comb begin
    res_nxt.outside = fin.outside;
    res_nxt.qxl = sat32(tex_t'(fin.ax.lo ? pos_t'(fin.ax.c1) : fin.ax.p1));
    res_nxt.qxh = sat32(tex_t'(fin.ax.hi ? pos_t'(fin.ax.c2) : fin.ax.p2));
    res_nxt.qyl = sat32(tex_t'(fin.ay.lo ? pos_t'(fin.ay.c1) : fin.ay.p1));
    res_nxt.qyh = sat32(tex_t'(fin.ay.hi ? pos_t'(fin.ay.c2) : fin.ay.p2));
    res_nxt.tul = sat32(fin.ax.lo ? fin.ax.t1 + floor_q(cq[0], cr[0], fin.ax.nlo_neg)
                                  : fin.ax.t1);
    res_nxt.tuh = sat32(fin.ax.hi ? fin.ax.t1 + floor_q(cq[1], cr[1], fin.ax.nhi_neg)
                                  : fin.ax.t2);
    res_nxt.tvl = sat32(fin.ay.lo ? fin.ay.t1 + floor_q(cq[2], cr[2], fin.ay.nlo_neg)
                                  : fin.ay.t1);
    res_nxt.tvh = sat32(fin.ay.hi ? fin.ay.t1 + floor_q(cq[3], cr[3], fin.ay.nhi_neg)
                                  : fin.ay.t2);
  end

  // ---------------- output register with skid ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (!ov_r || out_if.ready) begin
      ov_r <= sv_r || (en && v_r[NSTG-1]);
      sv_r <= 1'b0;
    end else if (en && v_r[NSTG-1]) begin
      sv_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov_r || out_if.ready) begin
      od_r <= sv_r ? sd_r : res_nxt;
    end else if (en && v_r[NSTG-1]) begin
      sd_r <= res_nxt;
    end
  end

  assign out_if.valid          = ov_r;
  assign out_if.quad_x_low     = od_r.qxl;
  assign out_if.quad_x_high    = od_r.qxh;
  assign out_if.quad_y_low     = od_r.qyl;
  assign out_if.quad_y_high    = od_r.qyh;
  assign out_if.tex_u_low      = od_r.tul;
  assign out_if.tex_u_high     = od_r.tuh;
  assign out_if.tex_v_low      = od_r.tvl;
  assign out_if.tex_v_high     = od_r.tvh;
  assign out_if.outside_canvas = od_r.outside;

  // ---------------- assertions ----------------
  // skid is only used behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> ov_r)
    else $error("skid entry held without output valid");

  // tiled edges must straddle the bounds
  a_tile_cover: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_B] && sbb_r.ax.rep |->
      sbb_r.ax.p1 <= pos_t'(sbb_r.ax.b1) && sbb_r.ax.p2 > pos_t'(sbb_r.ax.b2))
    else $error("x tiling does not cover bounds");

  a_tile_cover_y: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_B] && sbb_r.ay.rep |->
      sbb_r.ay.p1 <= pos_t'(sbb_r.ay.b1) && sbb_r.ay.p2 > pos_t'(sbb_r.ay.b2))
    else $error("y tiling does not cover bounds");

  // x-axis clipping only in canvas mode, on a visible quad of nonzero tile size
  a_clip_ok: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_E] && (sbe_r.ax.lo || sbe_r.ax.hi) |->
      sbe_r.canvas && !sbe_r.outside && sbe_r.ax.d != '0)
    else $error("x clip on invalid quad");

  // output valid drops after reset
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !ov_r && !sv_r)
    else $error("output valid after reset");

endmodule

/* sv/tqc_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, MSB first.
module tqc_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tqc_pkg::DIV_NW-1:0]  num,
  input  logic [tqc_pkg::DIV_DW-1:0]  den,
  output logic [tqc_pkg::DIV_NW-1:0]  quo,
  output logic [tqc_pkg::DIV_DW-1:0]  rem
);
  import tqc_pkg::*;

  div_st_t st_r   [DIV_NW];
  div_st_t st_nxt [DIV_NW];
  div_st_t in_st;

  function automatic div_st_t div_step(div_st_t prev);
    logic [DIV_DW:0] trial;
    logic            fit;
    div_st_t         nx;
    trial  = {prev.rem, prev.num[DIV_NW-1]};
    fit    = trial >= {1'b0, prev.den};
    nx.den = prev.den;
    nx.num = {prev.num[DIV_NW-2:0], fit};
    nx.rem = fit ? DIV_DW'(trial - {1'b0, prev.den}) : trial[DIV_DW-1:0];
    return nx;
  endfunction

  assign in_st = '{rem: '0, num: num, den: den};

  always_comb begin
    st_nxt[0] = div_step(in_st);
    for (int k = 1; k < DIV_NW; k++) begin
      st_nxt[k] = div_step(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_NW; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign quo = st_r[DIV_NW-1].num;
  assign rem = st_r[DIV_NW-1].rem;

endmodule
